// File: hdl/level_meter_ballistics_defines.svh
// Assertion macros used by the level meter ballistics core RTL.
`ifndef LEVEL_METER_BALLISTICS_DEFINES_SVH
`define LEVEL_METER_BALLISTICS_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LMB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its trigger.
`define LMB_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lmb_pkg.sv
// Shared constants and types for the level meter ballistics block.
package lmb_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FALL_COEFF      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_READOUT_COEFF   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_HOLD_TICKS = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_HOLD_TICKS = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_THRESHOLD  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_READOUT_SOURCE  = 3'd5;

  // Readout source codes; any code other than rms follows the peak.
  localparam logic [1:0] SRC_RMS  = 2'd1;
  localparam logic [1:0] SRC_BOTH = 2'd2;

  // Reset values of the registers before truncation to their widths.
  localparam int FALL_COEFF_RST    = 2820;
  localparam int READOUT_COEFF_RST = 32768;
  localparam int PEAK_HOLD_RST     = 45;
  localparam int CLIP_HOLD_RST     = 90;

  // Control passed from the channel stage to the state update.
  typedef struct packed {
    logic adv;    // a word moves from the input register into the state
    logic clear;  // that word is a clear item
  } lmb_step_t;

endpackage

// File: hdl/lmb_if.sv
// Valid/ready channel interfaces for meter input words and result words.
interface lmb_in_if #(
  parameter int LEVEL_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [LEVEL_BITS-1:0] peak_level;
  logic signed [LEVEL_BITS-1:0] rms_level;

  modport source (output valid, output mode, output peak_level, output rms_level,
                  input ready);
  modport sink (input valid, input mode, input peak_level, input rms_level,
                output ready);
endinterface

interface lmb_out_if #(
  parameter int LEVEL_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [LEVEL_BITS-1:0] shown_peak;
  logic signed [LEVEL_BITS-1:0] shown_rms;
  logic signed [LEVEL_BITS-1:0] hold_level;
  logic signed [LEVEL_BITS-1:0] readout_level;
  logic                         clip_active;

  modport source (output valid, output shown_peak, output shown_rms,
                  output hold_level, output readout_level, output clip_active,
                  input ready);
  modport sink (input valid, input shown_peak, input shown_rms,
                input hold_level, input readout_level, input clip_active,
                output ready);
endinterface

// File: hdl/lmb_approach.sv
// One step of a level toward a target by a fractional coefficient.
module lmb_approach #(
  parameter int LEVEL_BITS = 16,
  parameter int COEFF_BITS = 16
) (
  input  logic signed [LEVEL_BITS-1:0] current,
  input  logic signed [LEVEL_BITS-1:0] target,
  input  logic        [COEFF_BITS-1:0] coeff,
  input  logic                         round_half,
  output logic signed [LEVEL_BITS-1:0] result
);

  localparam int W = LEVEL_BITS + COEFF_BITS + 2;

  logic signed [LEVEL_BITS:0] diff;
  logic signed [W-1:0]        prod;
  logic signed [W-1:0]        bias;
  logic signed [W-1:0]        sum;

  // The step lies between zero and the difference, so the sum never
  // leaves the span of current and target and fits the level width.
  assign diff = (LEVEL_BITS+1)'(target) - (LEVEL_BITS+1)'(current);
  assign prod = W'(diff) * $signed({{(W-COEFF_BITS){1'b0}}, coeff});
  assign bias = round_half ? $signed(W'(1) <<< (COEFF_BITS - 1)) : '0;
  assign sum  = W'(current) + ((prod + bias) >>> COEFF_BITS);
  assign result = sum[LEVEL_BITS-1:0];

endmodule

// File: hdl/lmb_core.sv
// Configuration registers, meter state and its per-word update.
`include "level_meter_ballistics_defines.svh"

module lmb_core #(
  parameter int LEVEL_BITS    = 16,
  parameter int COEFF_BITS    = 16,
  parameter int COUNT_BITS    = 16,
  parameter int CFG_DATA_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lmb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]          cfg_wr_data,
  input  lmb_pkg::lmb_step_t                step,
  input  logic signed [LEVEL_BITS-1:0]      peak_level,
  input  logic signed [LEVEL_BITS-1:0]      rms_level,
  output logic signed [LEVEL_BITS-1:0]      shown_peak,
  output logic signed [LEVEL_BITS-1:0]      shown_rms,
  output logic signed [LEVEL_BITS-1:0]      hold_level,
  output logic signed [LEVEL_BITS-1:0]      readout_level,
  output logic                              clip_active
);

  localparam logic signed [LEVEL_BITS-1:0] SILENCE =
    LEVEL_BITS'(-100 * (1 << (LEVEL_BITS - 8)));

  // Configuration registers.
  logic        [COEFF_BITS-1:0] fall_coeff_r;
  logic        [COEFF_BITS-1:0] readout_coeff_r;
  logic        [COUNT_BITS-1:0] peak_hold_ticks_r;
  logic        [COUNT_BITS-1:0] clip_hold_ticks_r;
  logic signed [LEVEL_BITS-1:0] clip_threshold_r;
  logic        [1:0]            readout_source_r;

  // Meter state.
  logic signed [LEVEL_BITS-1:0] peak_shown_r, peak_shown_nxt;
  logic signed [LEVEL_BITS-1:0] rms_shown_r, rms_shown_nxt;
  logic signed [LEVEL_BITS-1:0] peak_hold_r, peak_hold_nxt;
  logic        [COUNT_BITS-1:0] hold_counter_r, hold_counter_nxt;
  logic                         clip_flag_r, clip_flag_nxt;
  logic signed [LEVEL_BITS-1:0] clip_peak_r, clip_peak_nxt;
  logic        [COUNT_BITS-1:0] clip_counter_r, clip_counter_nxt;
  logic signed [LEVEL_BITS-1:0] readout_r, readout_nxt;

  logic signed [LEVEL_BITS-1:0] peak_fall, rms_fall, hold_fall, readout_step;
  logic signed [LEVEL_BITS-1:0] readout_target;
  logic        [COUNT_BITS-1:0] hold_dec, clip_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_coeff_r      <= COEFF_BITS'(lmb_pkg::FALL_COEFF_RST);
      readout_coeff_r   <= COEFF_BITS'(lmb_pkg::READOUT_COEFF_RST);
      peak_hold_ticks_r <= COUNT_BITS'(lmb_pkg::PEAK_HOLD_RST);
      clip_hold_ticks_r <= COUNT_BITS'(lmb_pkg::CLIP_HOLD_RST);
      clip_threshold_r  <= '0;
      readout_source_r  <= lmb_pkg::SRC_BOTH;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lmb_pkg::CFG_FALL_COEFF:      fall_coeff_r      <= cfg_wr_data[COEFF_BITS-1:0];
        lmb_pkg::CFG_READOUT_COEFF:   readout_coeff_r   <= cfg_wr_data[COEFF_BITS-1:0];
        lmb_pkg::CFG_PEAK_HOLD_TICKS: peak_hold_ticks_r <= cfg_wr_data[COUNT_BITS-1:0];
        lmb_pkg::CFG_CLIP_HOLD_TICKS: clip_hold_ticks_r <= cfg_wr_data[COUNT_BITS-1:0];
        lmb_pkg::CFG_CLIP_THRESHOLD:  clip_threshold_r  <= $signed(cfg_wr_data[LEVEL_BITS-1:0]);
        lmb_pkg::CFG_READOUT_SOURCE:  readout_source_r  <= cfg_wr_data[1:0];
        default: ;
      endcase
    end
  end

  lmb_approach #(.LEVEL_BITS(LEVEL_BITS), .COEFF_BITS(COEFF_BITS)) u_peak_fall (
    .current(peak_shown_r), .target(peak_level), .coeff(fall_coeff_r),
    .round_half(1'b0), .result(peak_fall)
  );

  lmb_approach #(.LEVEL_BITS(LEVEL_BITS), .COEFF_BITS(COEFF_BITS)) u_rms_fall (
    .current(rms_shown_r), .target(rms_level), .coeff(fall_coeff_r),
    .round_half(1'b0), .result(rms_fall)
  );

  lmb_approach #(.LEVEL_BITS(LEVEL_BITS), .COEFF_BITS(COEFF_BITS)) u_hold_fall (
    .current(peak_hold_r), .target(peak_level), .coeff(fall_coeff_r),
    .round_half(1'b0), .result(hold_fall)
  );

  lmb_approach #(.LEVEL_BITS(LEVEL_BITS), .COEFF_BITS(COEFF_BITS)) u_readout (
    .current(readout_r), .target(readout_target), .coeff(readout_coeff_r),
    .round_half(1'b1), .result(readout_step)
  );

  assign hold_dec = (hold_counter_r != '0) ? hold_counter_r - 1'b1 : '0;
  assign clip_dec = (clip_counter_r != '0) ? clip_counter_r - 1'b1 : '0;

  // The readout chases the selected level, or the held clip peak when the
  // clip latch is set after this tick and its peak is higher.
  always_comb begin
    readout_target = (readout_source_r == lmb_pkg::SRC_RMS) ? rms_level : peak_level;
    if (clip_flag_nxt && (clip_peak_nxt > readout_target)) begin
      readout_target = clip_peak_nxt;
    end
  end

  always_comb begin
    peak_shown_nxt   = peak_shown_r;
    rms_shown_nxt    = rms_shown_r;
    peak_hold_nxt    = peak_hold_r;
    hold_counter_nxt = hold_counter_r;
    clip_flag_nxt    = clip_flag_r;
    clip_peak_nxt    = clip_peak_r;
    clip_counter_nxt = clip_counter_r;
    readout_nxt      = readout_r;
    if (step.clear) begin
      peak_hold_nxt    = SILENCE;
      hold_counter_nxt = '0;
      clip_flag_nxt    = 1'b0;
      clip_peak_nxt    = SILENCE;
      clip_counter_nxt = '0;
    end else begin
      peak_shown_nxt = (peak_level >= peak_shown_r) ? peak_level : peak_fall;
      rms_shown_nxt  = (rms_level >= rms_shown_r) ? rms_level : rms_fall;

      if (peak_level >= peak_hold_r) begin
        peak_hold_nxt    = peak_level;
        hold_counter_nxt = peak_hold_ticks_r;
      end else begin
        hold_counter_nxt = hold_dec;
        if (hold_dec == '0) begin
          peak_hold_nxt = hold_fall;
        end
      end

      if (peak_level >= clip_threshold_r) begin
        clip_flag_nxt    = 1'b1;
        clip_counter_nxt = clip_hold_ticks_r;
        if (peak_level > clip_peak_r) begin
          clip_peak_nxt = peak_level;
        end
      end else if (clip_flag_r) begin
        clip_counter_nxt = clip_dec;
        if (clip_dec == '0) begin
          clip_flag_nxt = 1'b0;
          clip_peak_nxt = SILENCE;
        end
      end

      readout_nxt = readout_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_shown_r   <= SILENCE;
      rms_shown_r    <= SILENCE;
      peak_hold_r    <= SILENCE;
      hold_counter_r <= '0;
      clip_flag_r    <= 1'b0;
      clip_peak_r    <= SILENCE;
      clip_counter_r <= '0;
      readout_r      <= SILENCE;
    end else if (step.adv) begin
      peak_shown_r   <= peak_shown_nxt;
      rms_shown_r    <= rms_shown_nxt;
      peak_hold_r    <= peak_hold_nxt;
      hold_counter_r <= hold_counter_nxt;
      clip_flag_r    <= clip_flag_nxt;
      clip_peak_r    <= clip_peak_nxt;
      clip_counter_r <= clip_counter_nxt;
      readout_r      <= readout_nxt;
    end
  end

  assign shown_peak    = peak_shown_r;
  assign shown_rms     = rms_shown_r;
  assign hold_level    = peak_hold_r;
  assign readout_level = readout_r;
  assign clip_active   = clip_flag_r;

  `LMB_ASSERT(a_clip_peak_idle, !clip_flag_r |-> (clip_peak_r == SILENCE), "clip peak kept without clip")
  `LMB_ASSERT_NEXT(a_state_holds, !step.adv, $stable(peak_shown_r) && $stable(readout_r), "state moved without a word")
  `LMB_ASSERT_NEXT(a_clear_drops, step.adv && step.clear, !clip_flag_r && (hold_counter_r == '0) && (peak_hold_r == SILENCE), "clear left hold or clip")
  `LMB_ASSERT_NEXT(a_hold_capture, step.adv && !step.clear && (peak_level >= peak_hold_r), peak_hold_r == $past(peak_level), "new peak not captured by hold")

endmodule

// File: hdl/level_meter_ballistics.sv
// Level meter ballistics top level: input register, state update, result handshake.
// A word is registered in the input register, then moves into the meter state, which is the result.
// Throughput: one word per cycle while results are taken; the four level updates run in parallel.
// Reset (rst_n low, synchronous) empties both stages, loads the register defaults and
// sets all displayed levels to silence with hold and clip state cleared.
module level_meter_ballistics #(
  parameter int  LEVEL_BITS = 16,
  parameter int  COEFF_BITS = 16,
  parameter int  COUNT_BITS = 16,
  localparam int CFG_DATA_BITS =
    (LEVEL_BITS >= COEFF_BITS && LEVEL_BITS >= COUNT_BITS) ? LEVEL_BITS :
    (COEFF_BITS >= COUNT_BITS) ? COEFF_BITS : COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lmb_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]         cfg_wr_data,
  lmb_in_if.sink                           in_ch,
  lmb_out_if.source                        out_ch
);

  // The input register holds one word until the state can take it. The
  // meter state itself is the result register: it only changes when a
  // word advances, and a word only advances when the previous result has
  // been taken or is being taken in the same cycle.
  logic                         in_v_r;
  logic                         in_mode_r;
  logic signed [LEVEL_BITS-1:0] in_peak_r;
  logic signed [LEVEL_BITS-1:0] in_rms_r;
  logic                         out_v_r;
  logic                         in_ready;
  lmb_pkg::lmb_step_t           step;

  assign step.adv   = in_v_r && (!out_v_r || out_ch.ready);
  assign step.clear = in_mode_r;

  // The input register frees up in the same cycle its word advances, so a
  // new word can follow every cycle while results are drained.
  assign in_ready    = !in_v_r || step.adv;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      in_mode_r <= in_ch.mode;
      in_peak_r <= in_ch.peak_level;
      in_rms_r  <= in_ch.rms_level;
    end
  end

  // A result stays valid until taken; a new one replaces it in the same
  // cycle it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step.adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_v_r;

  lmb_core #(
    .LEVEL_BITS(LEVEL_BITS),
    .COEFF_BITS(COEFF_BITS),
    .COUNT_BITS(COUNT_BITS),
    .CFG_DATA_BITS(CFG_DATA_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .step         (step),
    .peak_level   (in_peak_r),
    .rms_level    (in_rms_r),
    .shown_peak   (out_ch.shown_peak),
    .shown_rms    (out_ch.shown_rms),
    .hold_level   (out_ch.hold_level),
    .readout_level(out_ch.readout_level),
    .clip_active  (out_ch.clip_active)
  );

endmodule
